// ===== hdl/cbez_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and helpers for the cubic Bezier evaluator.
// No dependencies; imported by all modules of the block.
package cbez_pkg;

    localparam int T_FRAC_BITS_DEF = 16;
    localparam int COORD_BITS_DEF  = 24;

    localparam int NUM_PTS     = 4;
    localparam int NUM_REGS    = 2 * NUM_PTS;
    localparam int REG_IDX_W   = $clog2(NUM_REGS);

    localparam int WGT_STAGES  = 3;
    localparam int AXIS_STAGES = 4;
    localparam int PIPE_DEPTH  = WGT_STAGES + AXIS_STAGES;

    // Register indexes of the configuration port
    localparam logic [REG_IDX_W-1:0] REG_P0_X = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_P0_Y = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_P1_X = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_P1_Y = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_P2_X = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_P2_Y = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_P3_X = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_P3_Y = 3'd7;

    // Bernstein weight width: weights sum to 2^(3F), each at most 2^(3F)
    function automatic int wgt_bits(input int frac_bits);
        return 3 * frac_bits + 1;
    endfunction

endpackage

// ===== hdl/cbez_weight.sv =====
`timescale 1ns / 1ps
// Bernstein weight pipeline: t -> u^3, 3tu^2, 3t^2u, t^3 over three stages.
// Depends on cbez_pkg.
module cbez_weight #(
    parameter int T_FRAC_BITS = cbez_pkg::T_FRAC_BITS_DEF
) (
    input  logic                                            i_clk,
    input  logic                                            i_en,
    input  logic [T_FRAC_BITS:0]                            i_t,
    output logic [cbez_pkg::wgt_bits(T_FRAC_BITS)-1:0]      o_w [cbez_pkg::NUM_PTS]
);
    import cbez_pkg::*;

    localparam int TW = T_FRAC_BITS + 1;
    localparam int SW = 2 * T_FRAC_BITS + 1;
    localparam int WW = wgt_bits(T_FRAC_BITS);
    localparam logic [TW-1:0] T_ONE = TW'(1) << T_FRAC_BITS;

    logic [TW-1:0]   r_s1_t, r_s1_u;
    logic [TW:0]     r_s1_u3;
    logic [TW-1:0]   r_s2_t, r_s2_u;
    logic [SW-1:0]   r_s2_tt, r_s2_uu, r_s2_tu3;
    logic [WW-1:0]   r_w [NUM_PTS];

    logic [TW-1:0]   n_t, n_u;
    logic [TW+TW:0]  n_tu3;

    always_comb begin
        n_t   = (i_t > T_ONE) ? T_ONE : i_t;
        n_u   = T_ONE - n_t;
        n_tu3 = (TW+TW+1)'(r_s1_t) * (TW+TW+1)'(r_s1_u3);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // stage 1: clamp, complement, 3u
            r_s1_t  <= n_t;
            r_s1_u  <= n_u;
            r_s1_u3 <= {n_u, 1'b0} + {1'b0, n_u};
            // stage 2: second-order products
            r_s2_t   <= r_s1_t;
            r_s2_u   <= r_s1_u;
            r_s2_tt  <= SW'(r_s1_t * r_s1_t);
            r_s2_uu  <= SW'(r_s1_u * r_s1_u);
            r_s2_tu3 <= n_tu3[SW-1:0];
            // stage 3: cubic weights
            r_w[0] <= WW'(r_s2_uu  * r_s2_u);
            r_w[1] <= WW'(r_s2_tu3 * r_s2_u);
            r_w[2] <= WW'(r_s2_tu3 * r_s2_t);
            r_w[3] <= WW'(r_s2_tt  * r_s2_t);
        end
    end

    assign o_w = r_w;

endmodule

// ===== hdl/cbez_axis.sv =====
`timescale 1ns / 1ps
// One coordinate axis: weighted sum of four control coordinates, rounded.
// Four stages: split products, recombine, pair sums, final sum. Uses cbez_pkg.
module cbez_axis #(
    parameter int T_FRAC_BITS = cbez_pkg::T_FRAC_BITS_DEF,
    parameter int COORD_BITS  = cbez_pkg::COORD_BITS_DEF
) (
    input  logic                                            i_clk,
    input  logic                                            i_en,
    input  logic [cbez_pkg::wgt_bits(T_FRAC_BITS)-1:0]      i_w [cbez_pkg::NUM_PTS],
    input  logic signed [COORD_BITS-1:0]                    i_p [cbez_pkg::NUM_PTS],
    output logic signed [COORD_BITS-1:0]                    o_point
);
    import cbez_pkg::*;

    localparam int WW   = wgt_bits(T_FRAC_BITS);
    localparam int WL   = WW / 2;
    localparam int WH   = WW - WL;
    localparam int PLW  = WL + 1 + COORD_BITS;
    localparam int PHW  = WH + 1 + COORD_BITS;
    localparam int SUMW = 3 * T_FRAC_BITS + COORD_BITS + 2;
    localparam int RPOS = 3 * T_FRAC_BITS;
    localparam logic signed [SUMW-1:0] HALF = SUMW'(1) << (RPOS - 1);

    logic signed [PLW-1:0]  r_pl [NUM_PTS];
    logic signed [PHW-1:0]  r_ph [NUM_PTS];
    logic signed [SUMW-1:0] r_term [NUM_PTS];
    logic signed [SUMW-1:0] r_s01, r_s23;
    logic signed [COORD_BITS-1:0] r_point;
    logic signed [SUMW-1:0] n_sum;

    assign n_sum = r_s01 + r_s23;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < NUM_PTS; i++) begin
                r_pl[i]   <= $signed({1'b0, i_w[i][WL-1:0]}) * i_p[i];
                r_ph[i]   <= $signed({1'b0, i_w[i][WW-1:WL]}) * i_p[i];
                r_term[i] <= $signed({r_ph[i], {WL{1'b0}}}) + SUMW'(r_pl[i]);
            end
            r_s01   <= r_term[0] + r_term[1];
            r_s23   <= r_term[2] + r_term[3] + HALF;
            r_point <= n_sum[RPOS +: COORD_BITS];
        end
    end

    assign o_point = r_point;

endmodule

// ===== hdl/cubic_bezier_2d_eval_unit.sv =====
`timescale 1ns / 1ps
// Planar cubic Bezier evaluator, top level. Uses cbez_pkg, cbez_weight, cbez_axis.
// Throughput one point per cycle unless m_axis_tready stalls the output. Three weight and
// four multiply/accumulate stages share one stall enable. The user must write control
// points through the register port only while the pipeline is empty; the block does not
// enforce this. Synchronous active-low reset clears valid bits and all control points to 0.
module cubic_bezier_2d_eval_unit #(
    parameter int T_FRAC_BITS = cbez_pkg::T_FRAC_BITS_DEF,
    parameter int COORD_BITS  = cbez_pkg::COORD_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [cbez_pkg::REG_IDX_W-1:0]         i_cfg_addr,
    input  logic [COORD_BITS-1:0]                  i_cfg_wdata,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [T_FRAC_BITS:0] param_t, rest zero
    input  logic [((T_FRAC_BITS+8)/8)*8-1:0]       s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // [COORD_BITS-1:0] point_x, [2*COORD_BITS-1:COORD_BITS] point_y, rest zero
    output logic [((2*COORD_BITS+7)/8)*8-1:0]      m_axis_tdata
);
    import cbez_pkg::*;

    localparam int WW   = wgt_bits(T_FRAC_BITS);
    localparam int OUTW = ((2 * COORD_BITS + 7) / 8) * 8;

    logic [COORD_BITS-1:0] r_coord [NUM_REGS];
    logic [PIPE_DEPTH-1:0] r_vld;
    logic                  en;
    logic [WW-1:0]         w [NUM_PTS];
    logic signed [COORD_BITS-1:0] px [NUM_PTS];
    logic signed [COORD_BITS-1:0] py [NUM_PTS];
    logic signed [COORD_BITS-1:0] point_x, point_y;

    assign en            = !r_vld[PIPE_DEPTH-1] || m_axis_tready;
    assign s_axis_tready = en && i_rst_n;
    assign m_axis_tvalid = r_vld[PIPE_DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            for (int i = 0; i < NUM_REGS; i++) begin
                r_coord[i] <= '0;
            end
        end else begin
            if (en) begin
                r_vld <= {r_vld[PIPE_DEPTH-2:0], s_axis_tvalid};
            end
            if (i_cfg_we) begin
                r_coord[i_cfg_addr] <= i_cfg_wdata;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_PTS; i++) begin
            px[i] = $signed(r_coord[2 * i]);
            py[i] = $signed(r_coord[2 * i + 1]);
        end
    end

    cbez_weight #(
        .T_FRAC_BITS(T_FRAC_BITS)
    ) u_weight (
        .i_clk (i_clk),
        .i_en  (en),
        .i_t   (s_axis_tdata[T_FRAC_BITS:0]),
        .o_w   (w)
    );

    cbez_axis #(
        .T_FRAC_BITS(T_FRAC_BITS),
        .COORD_BITS (COORD_BITS)
    ) u_axis_x (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_w     (w),
        .i_p     (px),
        .o_point (point_x)
    );

    cbez_axis #(
        .T_FRAC_BITS(T_FRAC_BITS),
        .COORD_BITS (COORD_BITS)
    ) u_axis_y (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_w     (w),
        .i_p     (py),
        .o_point (point_y)
    );

    assign m_axis_tdata = OUTW'({point_y, point_x});

endmodule
